>>> design/wlc_pkg.sv
// wlc_pkg: shared types and constants of the word language classifier
// holds the language bit codes, the letter range table and the queue item type
// no dependencies
package wlc_pkg;

  localparam int NLANG = 12;
  localparam int CP_W  = 21;
  localparam int LANG_W = 4;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [NLANG-1:0] L_CHI = 12'h001;
  localparam logic [NLANG-1:0] L_ENG = 12'h002;
  localparam logic [NLANG-1:0] L_SPA = 12'h004;
  localparam logic [NLANG-1:0] L_RUS = 12'h008;
  localparam logic [NLANG-1:0] L_POR = 12'h010;
  localparam logic [NLANG-1:0] L_JPN = 12'h020;
  localparam logic [NLANG-1:0] L_GER = 12'h040;
  localparam logic [NLANG-1:0] L_KOR = 12'h080;
  localparam logic [NLANG-1:0] L_TUR = 12'h100;
  localparam logic [NLANG-1:0] L_ITA = 12'h200;
  localparam logic [NLANG-1:0] L_RUM = 12'h400;
  localparam logic [NLANG-1:0] L_SLO = 12'h800;
  localparam logic [NLANG-1:0] L_CJK = L_CHI | L_JPN | L_KOR;
  localparam logic [NLANG-1:0] L_LAT = L_ENG | L_GER | L_POR | L_SPA | L_RUM | L_SLO;
  localparam logic [NLANG-1:0] ALL_LANGS = '1;

  localparam logic [LANG_W-1:0] LANG_NONE = 4'd0;

  // one classified character as it sits in the queue
  typedef struct packed {
    logic [NLANG-1:0]  letter_set;
    logic              is_interword;
    logic [LANG_W-1:0] hint;
    logic              word_end;
  } wlc_item_t;

  typedef struct packed {
    logic      valid;
    wlc_item_t item;
  } wlc_push_t;

  function automatic logic in_rng(input logic [CP_W-1:0] cp,
                                  input logic [CP_W-1:0] lo,
                                  input logic [CP_W-1:0] hi);
    return (cp >= lo) && (cp <= hi);
  endfunction

  // union of the language sets of every range that holds the code point
  function automatic logic [NLANG-1:0] letter_set(input logic [CP_W-1:0] cp);
    logic [NLANG-1:0] acc;
    acc = '0;
    // cjk ideographs and symbols
    if (in_rng(cp, 21'h031C0, 21'h031FF)) acc |= L_CJK;
    if (in_rng(cp, 21'h03220, 21'h0325F)) acc |= L_CJK;
    if (in_rng(cp, 21'h03280, 21'h032BF)) acc |= L_CJK;
    if (in_rng(cp, 21'h0337B, 21'h0337F)) acc |= L_CJK;
    if (in_rng(cp, 21'h03400, 21'h04DB5)) acc |= L_CJK;
    if (in_rng(cp, 21'h04E00, 21'h09FBB)) acc |= L_CJK;
    if (in_rng(cp, 21'h0F900, 21'h0FA6B)) acc |= L_CJK;
    // chinese
    if (in_rng(cp, 21'h03100, 21'h031FF)) acc |= L_CHI;
    if (in_rng(cp, 21'h031A0, 21'h031BF)) acc |= L_CHI;
    if (in_rng(cp, 21'h0A700, 21'h0A71F)) acc |= L_CHI;
    // japanese
    if (in_rng(cp, 21'h03040, 21'h0309F)) acc |= L_JPN;
    if (in_rng(cp, 21'h030A0, 21'h030FF)) acc |= L_JPN;
    if (in_rng(cp, 21'h031D0, 21'h032FE)) acc |= L_JPN;
    if (in_rng(cp, 21'h03300, 21'h03357)) acc |= L_JPN;
    if (in_rng(cp, 21'h0FF66, 21'h0FF9F)) acc |= L_JPN;
    if (in_rng(cp, 21'h03180, 21'h0319F)) acc |= L_JPN;
    // korean
    if (in_rng(cp, 21'h01100, 21'h011FF)) acc |= L_KOR;
    if (in_rng(cp, 21'h03130, 21'h0317F)) acc |= L_KOR;
    if (in_rng(cp, 21'h03200, 21'h0321F)) acc |= L_KOR;
    if (in_rng(cp, 21'h03260, 21'h0327F)) acc |= L_KOR;
    if (in_rng(cp, 21'h0AC00, 21'h0D7A3)) acc |= L_KOR;
    if (in_rng(cp, 21'h0FFA0, 21'h0FFDF)) acc |= L_KOR;
    // basic latin
    if (in_rng(cp, 21'h00041, 21'h0005A)) acc |= L_LAT;
    if (in_rng(cp, 21'h00061, 21'h0007A)) acc |= L_LAT;
    // russian
    if (in_rng(cp, 21'h00410, 21'h0042F)) acc |= L_RUS;
    if (in_rng(cp, 21'h00430, 21'h0044F)) acc |= L_RUS;
    if (in_rng(cp, 21'h00401, 21'h00401)) acc |= L_RUS;
    if (in_rng(cp, 21'h00451, 21'h00451)) acc |= L_RUS;
    // german
    if (in_rng(cp, 21'h000C4, 21'h000C4)) acc |= L_GER;
    if (in_rng(cp, 21'h000D6, 21'h000D6)) acc |= L_GER;
    if (in_rng(cp, 21'h000DC, 21'h000DC)) acc |= L_GER;
    if (in_rng(cp, 21'h000E4, 21'h000E4)) acc |= L_GER;
    if (in_rng(cp, 21'h000F6, 21'h000F6)) acc |= L_GER;
    if (in_rng(cp, 21'h000FC, 21'h000FC)) acc |= L_GER;
    if (in_rng(cp, 21'h000DF, 21'h000DF)) acc |= L_GER;
    // portuguese
    if (in_rng(cp, 21'h000C0, 21'h000C3)) acc |= L_POR;
    if (in_rng(cp, 21'h000E0, 21'h000E3)) acc |= L_POR;
    if (in_rng(cp, 21'h000C7, 21'h000C7)) acc |= L_POR;
    if (in_rng(cp, 21'h000E7, 21'h000E7)) acc |= L_POR;
    if (in_rng(cp, 21'h000C9, 21'h000CA)) acc |= L_POR;
    if (in_rng(cp, 21'h000E9, 21'h000EA)) acc |= L_POR;
    if (in_rng(cp, 21'h000CD, 21'h000CD)) acc |= L_POR;
    if (in_rng(cp, 21'h000ED, 21'h000ED)) acc |= L_POR;
    if (in_rng(cp, 21'h000D3, 21'h000D5)) acc |= L_POR;
    if (in_rng(cp, 21'h000F3, 21'h000F5)) acc |= L_POR;
    if (in_rng(cp, 21'h000DA, 21'h000DA)) acc |= L_POR;
    if (in_rng(cp, 21'h000FA, 21'h000FA)) acc |= L_POR;
    // italian
    if (in_rng(cp, 21'h00041, 21'h00049)) acc |= L_ITA;
    if (in_rng(cp, 21'h0004C, 21'h00056)) acc |= L_ITA;
    if (in_rng(cp, 21'h0005A, 21'h0005A)) acc |= L_ITA;
    if (in_rng(cp, 21'h00061, 21'h00069)) acc |= L_ITA;
    if (in_rng(cp, 21'h0006C, 21'h00076)) acc |= L_ITA;
    if (in_rng(cp, 21'h0007A, 21'h0007A)) acc |= L_ITA;
    if (in_rng(cp, 21'h000C8, 21'h000C8)) acc |= L_ITA;
    if (in_rng(cp, 21'h000E8, 21'h000E8)) acc |= L_ITA;
    if (in_rng(cp, 21'h000D3, 21'h000D3)) acc |= L_ITA;
    if (in_rng(cp, 21'h000F3, 21'h000F3)) acc |= L_ITA;
    if (in_rng(cp, 21'h000CE, 21'h000CE)) acc |= L_ITA;
    if (in_rng(cp, 21'h000EE, 21'h000EE)) acc |= L_ITA;
    if (in_rng(cp, 21'h000CC, 21'h000CC)) acc |= L_ITA;
    if (in_rng(cp, 21'h000EC, 21'h000EC)) acc |= L_ITA;
    // spanish
    if (in_rng(cp, 21'h000C1, 21'h000C1)) acc |= L_SPA;
    if (in_rng(cp, 21'h000E1, 21'h000E1)) acc |= L_SPA;
    if (in_rng(cp, 21'h000C9, 21'h000C9)) acc |= L_SPA;
    if (in_rng(cp, 21'h000E9, 21'h000E9)) acc |= L_SPA;
    if (in_rng(cp, 21'h000CD, 21'h000CD)) acc |= L_SPA;
    if (in_rng(cp, 21'h000ED, 21'h000ED)) acc |= L_SPA;
    if (in_rng(cp, 21'h000D3, 21'h000D3)) acc |= L_SPA;
    if (in_rng(cp, 21'h000F3, 21'h000F3)) acc |= L_SPA;
    if (in_rng(cp, 21'h000DA, 21'h000DA)) acc |= L_SPA;
    if (in_rng(cp, 21'h000FA, 21'h000FA)) acc |= L_SPA;
    if (in_rng(cp, 21'h000DC, 21'h000DC)) acc |= L_SPA;
    if (in_rng(cp, 21'h000FC, 21'h000FC)) acc |= L_SPA;
    if (in_rng(cp, 21'h000D1, 21'h000D1)) acc |= L_SPA;
    if (in_rng(cp, 21'h000F1, 21'h000F1)) acc |= L_SPA;
    // romanian
    if (in_rng(cp, 21'h00102, 21'h00103)) acc |= L_RUM;
    if (in_rng(cp, 21'h000C2, 21'h000C2)) acc |= L_RUM;
    if (in_rng(cp, 21'h000E2, 21'h000E2)) acc |= L_RUM;
    if (in_rng(cp, 21'h000CE, 21'h000CE)) acc |= L_RUM;
    if (in_rng(cp, 21'h000EE, 21'h000EE)) acc |= L_RUM;
    if (in_rng(cp, 21'h00218, 21'h0021B)) acc |= L_RUM;
    if (in_rng(cp, 21'h0015E, 21'h0015F)) acc |= L_RUM;
    if (in_rng(cp, 21'h00162, 21'h00163)) acc |= L_RUM;
    // slovak
    if (in_rng(cp, 21'h000C1, 21'h000C1)) acc |= L_SLO;
    if (in_rng(cp, 21'h000E1, 21'h000E1)) acc |= L_SLO;
    if (in_rng(cp, 21'h000C4, 21'h000C4)) acc |= L_SLO;
    if (in_rng(cp, 21'h000E4, 21'h000E4)) acc |= L_SLO;
    if (in_rng(cp, 21'h0010C, 21'h0010F)) acc |= L_SLO;
    if (in_rng(cp, 21'h000C9, 21'h000C9)) acc |= L_SLO;
    if (in_rng(cp, 21'h000E9, 21'h000E9)) acc |= L_SLO;
    if (in_rng(cp, 21'h00139, 21'h0013A)) acc |= L_SLO;
    if (in_rng(cp, 21'h0013D, 21'h0013E)) acc |= L_SLO;
    if (in_rng(cp, 21'h00147, 21'h00148)) acc |= L_SLO;
    if (in_rng(cp, 21'h000D3, 21'h000D4)) acc |= L_SLO;
    if (in_rng(cp, 21'h000F3, 21'h000F4)) acc |= L_SLO;
    if (in_rng(cp, 21'h00154, 21'h00155)) acc |= L_SLO;
    if (in_rng(cp, 21'h00160, 21'h00161)) acc |= L_SLO;
    if (in_rng(cp, 21'h00164, 21'h00165)) acc |= L_SLO;
    if (in_rng(cp, 21'h000DA, 21'h000DA)) acc |= L_SLO;
    if (in_rng(cp, 21'h000FA, 21'h000FA)) acc |= L_SLO;
    if (in_rng(cp, 21'h000DD, 21'h000DD)) acc |= L_SLO;
    if (in_rng(cp, 21'h000FD, 21'h000FD)) acc |= L_SLO;
    if (in_rng(cp, 21'h0017D, 21'h0017E)) acc |= L_SLO;
    if (in_rng(cp, 21'h001F1, 21'h001F3)) acc |= L_SLO;
    if (in_rng(cp, 21'h001C4, 21'h001C4)) acc |= L_SLO;
    // turkish
    if (in_rng(cp, 21'h00041, 21'h00050)) acc |= L_TUR;
    if (in_rng(cp, 21'h00052, 21'h00056)) acc |= L_TUR;
    if (in_rng(cp, 21'h00059, 21'h0005A)) acc |= L_TUR;
    if (in_rng(cp, 21'h00061, 21'h00070)) acc |= L_TUR;
    if (in_rng(cp, 21'h00072, 21'h00076)) acc |= L_TUR;
    if (in_rng(cp, 21'h00079, 21'h0007A)) acc |= L_TUR;
    if (in_rng(cp, 21'h000C7, 21'h000C7)) acc |= L_TUR;
    if (in_rng(cp, 21'h000D6, 21'h000D6)) acc |= L_TUR;
    if (in_rng(cp, 21'h000DC, 21'h000DC)) acc |= L_TUR;
    if (in_rng(cp, 21'h000E7, 21'h000E7)) acc |= L_TUR;
    if (in_rng(cp, 21'h000F6, 21'h000F6)) acc |= L_TUR;
    if (in_rng(cp, 21'h000FC, 21'h000FC)) acc |= L_TUR;
    if (in_rng(cp, 21'h0011E, 21'h0011F)) acc |= L_TUR;
    if (in_rng(cp, 21'h00130, 21'h00131)) acc |= L_TUR;
    if (in_rng(cp, 21'h0015E, 21'h0015F)) acc |= L_TUR;
    return acc;
  endfunction

endpackage

>>> design/word_language_classifier_core.sv
// word_language_classifier_core: one character accepted per cycle while the queue is not full
// a word's result is registered: its last character passes through the queue and then the
// result register; queued characters ahead of it and a stalled output hold it back
// throughput: one character per cycle unless stalled; the front classifies, a four-entry queue
// decouples it from the back, which folds one queued character per cycle unless a word end waits on out_stall
// reset: synchronous active-low rst_n empties the queue and the result register
// and returns the word state to all languages, no failure, no letter seen
module word_language_classifier_core
  import wlc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CP_W-1:0]   in_code_point,
  input  logic              in_is_interword,
  input  logic [LANG_W-1:0] in_hint_language,
  input  logic              in_word_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LANG_W-1:0] out_detected_language,
  output logic [NLANG-1:0]  out_candidate_mask
);

  wlc_push_t push;
  logic      q_full;
  logic      q_valid;
  wlc_item_t q_head;
  logic      q_pop;

  wlc_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_code_point    (in_code_point),
    .in_is_interword  (in_is_interword),
    .in_hint_language (in_hint_language),
    .in_word_end      (in_word_end),
    .q_full           (q_full),
    .push             (push)
  );

  wlc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  wlc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_head                (q_head),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_detected_language (out_detected_language),
    .out_candidate_mask    (out_candidate_mask)
  );

endmodule

>>> design/wlc_front.sv
// wlc_front: accepts characters and classifies them into language sets
// depends on wlc_pkg; feeds wlc_queue
module wlc_front
  import wlc_pkg::*;
(
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CP_W-1:0]   in_code_point,
  input  logic              in_is_interword,
  input  logic [LANG_W-1:0] in_hint_language,
  input  logic              in_word_end,
  input  logic              q_full,
  output wlc_push_t         push
);

  // stall comes from the registered queue count so it never follows in_valid
  assign in_stall = q_full;

  always_comb begin
    push.valid             = in_valid & ~in_stall;
    push.item.letter_set   = letter_set(in_code_point);
    push.item.is_interword = in_is_interword;
    push.item.hint         = in_hint_language;
    push.item.word_end     = in_word_end;
  end

endmodule

>>> design/wlc_queue.sv
// wlc_queue: short queue of classified characters between front and back
// depends on wlc_pkg
module wlc_queue
  import wlc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  wlc_push_t push,
  output logic      q_full,
  output logic      q_valid,
  output wlc_item_t q_head,
  input  logic      q_pop
);

  wlc_item_t        mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             do_pop;

  assign q_full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_head  = mem_r[rd_ptr_r];
  assign do_pop  = q_pop & q_valid;

  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push.valid, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> design/wlc_back.sv
// wlc_back: intersects letter sets over a word and picks the language
// depends on wlc_pkg; drains wlc_queue and holds the result register
module wlc_back
  import wlc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  wlc_item_t         q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LANG_W-1:0] out_detected_language,
  output logic [NLANG-1:0]  out_candidate_mask
);

  logic [NLANG-1:0]  surv_r, surv_nxt;
  logic              failed_r, failed_nxt;
  logic              seen_r, seen_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LANG_W-1:0] lang_r, lang_nxt;
  logic [NLANG-1:0]  mask_r, mask_nxt;

  logic              is_letter;
  logic [NLANG-1:0]  surv_upd;
  logic              failed_upd;
  logic              seen_upd;
  logic [NLANG-1:0]  fin_set;

  function automatic logic [LANG_W-1:0] pick_language(input logic [NLANG-1:0]  set,
                                                      input logic [LANG_W-1:0] hint);
    logic [LANG_W-1:0] lowest;
    logic [NLANG-1:0]  hint_oh;
    logic              several;
    logic              hint_ok;
    lowest = LANG_NONE;
    for (int i = NLANG - 1; i >= 0; i--) begin
      if (set[i]) lowest = LANG_W'(i + 1);
    end
    hint_oh = NLANG'(1) << (hint - 4'd1);
    several = (set & (set - 1'b1)) != '0;
    hint_ok = (hint >= 4'd1) && (hint <= LANG_W'(NLANG)) && ((set & hint_oh) != '0);
    if (set == '0) return LANG_NONE;
    if (several && hint_ok) return hint;
    return lowest;
  endfunction

  // a finished word may leave only when the result register is free or draining
  assign q_pop = q_valid & (~q_head.word_end | ~out_valid_r | ~out_stall);

  always_comb begin
    is_letter  = |q_head.letter_set;
    surv_upd   = is_letter ? (surv_r & q_head.letter_set) : surv_r;
    seen_upd   = seen_r | is_letter;
    failed_upd = failed_r | (~is_letter & ~q_head.is_interword);
    fin_set    = (failed_upd | ~seen_upd) ? '0 : surv_upd;

    surv_nxt      = surv_r;
    failed_nxt    = failed_r;
    seen_nxt      = seen_r;
    lang_nxt      = lang_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r & out_stall;

    if (q_pop) begin
      if (q_head.word_end) begin
        surv_nxt      = ALL_LANGS;
        failed_nxt    = 1'b0;
        seen_nxt      = 1'b0;
        lang_nxt      = pick_language(fin_set, q_head.hint);
        mask_nxt      = fin_set;
        out_valid_nxt = 1'b1;
      end else begin
        surv_nxt   = surv_upd;
        failed_nxt = failed_upd;
        seen_nxt   = seen_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    lang_r <= lang_nxt;
    mask_r <= mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surv_r      <= ALL_LANGS;
      failed_r    <= 1'b0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      surv_r      <= surv_nxt;
      failed_r    <= failed_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_detected_language = lang_r;
  assign out_candidate_mask    = mask_r;

endmodule

>>> bench/tb_word_language_classifier_core.sv
// testbench for word_language_classifier_core: random and directed words in, results checked
// against an in-bench classifier that keeps its own letter range table and word state
// depends on wlc_pkg and word_language_classifier_core
module tb_word_language_classifier_core;
  import wlc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int TAIL_CYCLES  = 10;

  // word state and expected results, updated on every accepted item
  class word_scoreboard;
    logic [NLANG-1:0]  alive;
    bit                failed;
    bit                seen;
    logic [LANG_W-1:0] want_lang[$];
    logic [NLANG-1:0]  want_mask[$];
    int                errors;

    function new();
      alive  = ALL_LANGS;
      failed = 0;
      seen   = 0;
      errors = 0;
    endfunction

    function bit hit(logic [CP_W-1:0] cp, int unsigned lo, int unsigned hi);
      return (cp >= lo) && (cp <= hi);
    endfunction

    // languages whose alphabet holds this code point
    function logic [NLANG-1:0] cover_of(logic [CP_W-1:0] cp);
      logic [NLANG-1:0] s;
      s = '0;
      if (hit(cp, 'h31C0, 'h31FF) || hit(cp, 'h3220, 'h325F) || hit(cp, 'h3280, 'h32BF) ||
          hit(cp, 'h337B, 'h337F) || hit(cp, 'h3400, 'h4DB5) || hit(cp, 'h4E00, 'h9FBB) ||
          hit(cp, 'hF900, 'hFA6B)) s |= L_CJK;
      if (hit(cp, 'h3100, 'h31FF) || hit(cp, 'hA700, 'hA71F)) s |= L_CHI;
      if (hit(cp, 'h3040, 'h30FF) || hit(cp, 'h31D0, 'h32FE) || hit(cp, 'h3300, 'h3357) ||
          hit(cp, 'hFF66, 'hFF9F) || hit(cp, 'h3180, 'h319F)) s |= L_JPN;
      if (hit(cp, 'h1100, 'h11FF) || hit(cp, 'h3130, 'h317F) || hit(cp, 'h3200, 'h321F) ||
          hit(cp, 'h3260, 'h327F) || hit(cp, 'hAC00, 'hD7A3) || hit(cp, 'hFFA0, 'hFFDF))
        s |= L_KOR;
      if (hit(cp, 'h41, 'h5A) || hit(cp, 'h61, 'h7A)) s |= L_LAT;
      if (hit(cp, 'h410, 'h44F) || cp == 'h401 || cp == 'h451) s |= L_RUS;
      if (cp == 'hC4 || cp == 'hD6 || cp == 'hDC || cp == 'hE4 || cp == 'hF6 ||
          cp == 'hFC || cp == 'hDF) s |= L_GER;
      if (hit(cp, 'hC0, 'hC3) || hit(cp, 'hE0, 'hE3) || cp == 'hC7 || cp == 'hE7 ||
          hit(cp, 'hC9, 'hCA) || hit(cp, 'hE9, 'hEA) || cp == 'hCD || cp == 'hED ||
          hit(cp, 'hD3, 'hD5) || hit(cp, 'hF3, 'hF5) || cp == 'hDA || cp == 'hFA)
        s |= L_POR;
      if (hit(cp, 'h41, 'h49) || hit(cp, 'h4C, 'h56) || cp == 'h5A || hit(cp, 'h61, 'h69) ||
          hit(cp, 'h6C, 'h76) || cp == 'h7A || cp == 'hC8 || cp == 'hE8 || cp == 'hD3 ||
          cp == 'hF3 || cp == 'hCE || cp == 'hEE || cp == 'hCC || cp == 'hEC) s |= L_ITA;
      if (cp == 'hC1 || cp == 'hE1 || cp == 'hC9 || cp == 'hE9 || cp == 'hCD ||
          cp == 'hED || cp == 'hD3 || cp == 'hF3 || cp == 'hDA || cp == 'hFA ||
          cp == 'hDC || cp == 'hFC || cp == 'hD1 || cp == 'hF1) s |= L_SPA;
      if (hit(cp, 'h102, 'h103) || cp == 'hC2 || cp == 'hE2 || cp == 'hCE || cp == 'hEE ||
          hit(cp, 'h218, 'h21B) || hit(cp, 'h15E, 'h15F) || hit(cp, 'h162, 'h163))
        s |= L_RUM;
      if (cp == 'hC1 || cp == 'hE1 || cp == 'hC4 || cp == 'hE4 || hit(cp, 'h10C, 'h10F) ||
          cp == 'hC9 || cp == 'hE9 || hit(cp, 'h139, 'h13A) || hit(cp, 'h13D, 'h13E) ||
          hit(cp, 'h147, 'h148) || hit(cp, 'hD3, 'hD4) || hit(cp, 'hF3, 'hF4) ||
          hit(cp, 'h154, 'h155) || hit(cp, 'h160, 'h161) || hit(cp, 'h164, 'h165) ||
          cp == 'hDA || cp == 'hFA || cp == 'hDD || cp == 'hFD || hit(cp, 'h17D, 'h17E) ||
          hit(cp, 'h1F1, 'h1F3) || cp == 'h1C4) s |= L_SLO;
      if (hit(cp, 'h41, 'h50) || hit(cp, 'h52, 'h56) || hit(cp, 'h59, 'h5A) ||
          hit(cp, 'h61, 'h70) || hit(cp, 'h72, 'h76) || hit(cp, 'h79, 'h7A) ||
          cp == 'hC7 || cp == 'hD6 || cp == 'hDC || cp == 'hE7 || cp == 'hF6 ||
          cp == 'hFC || hit(cp, 'h11E, 'h11F) || hit(cp, 'h130, 'h131) ||
          hit(cp, 'h15E, 'h15F)) s |= L_TUR;
      return s;
    endfunction

    // single survivor, else the hint if it survives, else the survivor with the lowest bit
    function logic [LANG_W-1:0] choose(logic [NLANG-1:0] set, logic [LANG_W-1:0] hint);
      if (set == '0) return LANG_NONE;
      if ((set & (set - 1'b1)) != '0 && hint >= 1 && hint <= NLANG && set[hint - 4'd1])
        return hint;
      for (int i = 0; i < NLANG; i++)
        if (set[i]) return LANG_W'(i + 1);
      return LANG_NONE;
    endfunction

    function void note_char(logic [CP_W-1:0] cp, logic iw, logic [LANG_W-1:0] hint,
                            logic last);
      logic [NLANG-1:0] cv_set;
      logic [NLANG-1:0] set;
      cv_set = cover_of(cp);
      if (cv_set != '0) begin
        alive &= cv_set;
        seen = 1;
      end else if (!iw) begin
        failed = 1;
      end
      if (last) begin
        set = (failed || !seen) ? '0 : alive;
        want_lang.insert(want_lang.size(), choose(set, hint));
        want_mask.insert(want_mask.size(), set);
        alive  = ALL_LANGS;
        failed = 0;
        seen   = 0;
      end
    endfunction

    function void check_result(logic [LANG_W-1:0] lang, logic [NLANG-1:0] mask);
      logic [LANG_W-1:0] lang_e;
      logic [NLANG-1:0]  mask_e;
      if (want_lang.size() == 0) begin
        errors++;
        $display("%0t: unexpected result language %0d mask %h", $time, lang, mask);
        return;
      end
      lang_e = want_lang.pop_front();
      mask_e = want_mask.pop_front();
      if (lang !== lang_e) begin
        errors++;
        $display("%0t: detected_language expected %0d actual %0d", $time, lang_e, lang);
      end
      if (mask !== mask_e) begin
        errors++;
        $display("%0t: candidate_mask expected %h actual %h", $time, mask_e, mask);
      end
    endfunction

    function int pending();
      return want_lang.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CP_W-1:0]   in_code_point = '0;
  logic              in_is_interword = 1'b0;
  logic [LANG_W-1:0] in_hint_language = '0;
  logic              in_word_end = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [LANG_W-1:0] out_detected_language;
  logic [NLANG-1:0]  out_candidate_mask;

  word_scoreboard sb = new();
  bit quiet = 0;
  int cycles = 0;

  word_language_classifier_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_code_point         (in_code_point),
    .in_is_interword       (in_is_interword),
    .in_hint_language      (in_hint_language),
    .in_word_end           (in_word_end),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_detected_language (out_detected_language),
    .out_candidate_mask    (out_candidate_mask)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_char(in_code_point, in_is_interword, in_hint_language, in_word_end);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_detected_language, out_candidate_mask);
  end

  initial begin
    forever begin
      @(negedge clk);
      out_stall = !quiet && ($urandom_range(99) < 11);
    end
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_char(input logic [CP_W-1:0] cp, input logic iw,
                           input logic [LANG_W-1:0] hint, input logic last);
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_code_point    = cp;
    in_is_interword  = iw;
    in_hint_language = hint;
    in_word_end      = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // a code point from one script family; family 6 is range borders
  function automatic logic [CP_W-1:0] pick_letter(int fam);
    int unsigned v;
    case (fam)
      0: v = $urandom_range(1) ? $urandom_range('h5A, 'h41) : $urandom_range('h7A, 'h61);
      1: v = ($urandom_range(9) < 7) ? $urandom_range('hFF, 'hC0)
                                     : $urandom_range('h21B, 'h100);
      2: begin
        case ($urandom_range(9))
          0: v = 'h401;
          1: v = 'h451;
          default: v = $urandom_range('h44F, 'h410);
        endcase
      end
      3: begin
        case ($urandom_range(4))
          0: v = $urandom_range('h4DB5, 'h3400);
          1: v = $urandom_range('hFA6B, 'hF900);
          2: v = $urandom_range('h32FE, 'h3100);
          3: v = $urandom_range('hA71F, 'hA700);
          default: v = $urandom_range('h9FBB, 'h4E00);
        endcase
      end
      4: begin
        case ($urandom_range(3))
          0: v = $urandom_range('hFF9F, 'hFF66);
          1: v = $urandom_range('h3357, 'h31D0);
          default: v = $urandom_range('h30FF, 'h3040);
        endcase
      end
      5: begin
        case ($urandom_range(4))
          0: v = $urandom_range('h11FF, 'h1100);
          1: v = $urandom_range('h327F, 'h3130);
          2: v = $urandom_range('hFFDF, 'hFFA0);
          default: v = $urandom_range('hD7A3, 'hAC00);
        endcase
      end
      default: begin
        case ($urandom_range(47))
          0: v = 'h40;      1: v = 'h41;      2: v = 'h5A;      3: v = 'h5B;
          4: v = 'h60;      5: v = 'h61;      6: v = 'h7A;      7: v = 'h7B;
          8: v = 'hBF;      9: v = 'hC0;      10: v = 'hFF;     11: v = 'h100;
          12: v = 'h400;    13: v = 'h40F;    14: v = 'h450;    15: v = 'h452;
          16: v = 'h10FF;   17: v = 'h1200;   18: v = 'h303F;   19: v = 'h30FF;
          20: v = 'h3100;   21: v = 'h32FF;   22: v = 'h3358;   23: v = 'h337A;
          24: v = 'h337B;   25: v = 'h337F;   26: v = 'h3380;   27: v = 'h33FF;
          28: v = 'h4DB6;   29: v = 'h4DFF;   30: v = 'h9FBC;   31: v = 'hA6FF;
          32: v = 'hA720;   33: v = 'hABFF;   34: v = 'hD7A4;   35: v = 'hF8FF;
          36: v = 'hFA6C;   37: v = 'hFF65;   38: v = 'hFFE0;   39: v = 'h1C4;
          40: v = 'h1F3;    41: v = 'h1F4;    42: v = 'h21B;    43: v = 'h21C;
          44: v = 'h3040;   45: v = 'h31A0;   46: v = 'h3180;   default: v = 'h317F;
        endcase
      end
    endcase
    return CP_W'(v);
  endfunction

  initial begin
    int sent;
    int fam;
    int len;
    int r;
    logic [CP_W-1:0]   cp;
    logic              iw;
    logic [LANG_W-1:0] hint;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed words
    send_char(21'h41, 1'b0, 4'd0, 1'b1);
    send_char(21'h61, 1'b0, 4'd3, 1'b0);
    send_char(21'h62, 1'b0, 4'd2, 1'b1);
    send_char(21'h4E00, 1'b0, 4'd6, 1'b1);
    send_char(21'h9FBB, 1'b0, 4'd15, 1'b1);
    // a non-letter that is not an interword mark fails the word
    send_char(21'h61, 1'b0, 4'd2, 1'b0);
    send_char(21'h30, 1'b0, 4'd2, 1'b0);
    send_char(21'h62, 1'b0, 4'd2, 1'b1);
    // only interword marks, no letter
    send_char(21'h2D, 1'b1, 4'd2, 1'b1);
    // latin then cyrillic leaves nothing
    send_char(21'h61, 1'b0, 4'd4, 1'b0);
    send_char(21'h410, 1'b0, 4'd4, 1'b1);
    send_char(21'h410, 1'b0, 4'd2, 1'b1);
    // beyond the unicode range, skipped as a mark
    send_char(21'h1FFFFF, 1'b1, 4'd14, 1'b0);
    send_char(21'h7A, 1'b0, 4'd12, 1'b1);
    send_char(21'h10FFFF, 1'b0, 4'd1, 1'b1);
    send_char(21'hAC00, 1'b0, 4'd8, 1'b0);
    send_char(21'hD7A3, 1'b0, 4'd8, 1'b1);
    send_char(21'h3040, 1'b0, 4'd13, 1'b0);
    send_char(21'h30FF, 1'b0, 4'd13, 1'b1);
    send_char(21'h44F, 1'b1, 4'd12, 1'b1);
    send_char(21'hDF, 1'b0, 4'd7, 1'b1);
    send_char(21'h61, 1'b1, 4'd12, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet = (sent >= 300 && sent < 420);
      fam = $urandom_range(6);
      len = $urandom_range(7, 1);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(99);
        iw = 1'($urandom_range(1));
        if (r < 80) begin
          cp = pick_letter(fam);
        end else if (r < 88) begin
          iw = 1'b1;
          case ($urandom_range(3))
            0: cp = 21'h2D;
            1: cp = 21'h27;
            2: cp = 21'h2019;
            default: cp = CP_W'($urandom_range('h10FFFF));
          endcase
        end else if (r < 93) begin
          cp = pick_letter($urandom_range(6));
        end else begin
          cp = CP_W'($urandom_range('h10FFFF));
        end
        hint = LANG_W'(($urandom_range(9) < 7) ? $urandom_range(12, 1) : $urandom_range(15));
        send_char(cp, iw, hint, k == len - 1);
        sent++;
      end
    end
    quiet = 0;
    in_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/wlc_pkg.sv
design/wlc_front.sv
design/wlc_queue.sv
design/wlc_back.sv
design/word_language_classifier_core.sv
bench/tb_word_language_classifier_core.sv
